/* rtl/irsc_pkg.sv */
// ----------------------------------------------------------------------------
// irsc_pkg: relation set types and tables
// Composition and converse tables of the thirteen basic interval relations.
// ----------------------------------------------------------------------------
package irsc_pkg;

  localparam int REL_W = 13;

  typedef logic [REL_W-1:0] rel_set_t;

  localparam rel_set_t REL_ALL = rel_set_t'((1 << REL_W) - 1);

  localparam rel_set_t R_EQ = 13'h0001;
  localparam rel_set_t R_B  = 13'h0002;
  localparam rel_set_t R_BI = 13'h0004;
  localparam rel_set_t R_D  = 13'h0008;
  localparam rel_set_t R_DI = 13'h0010;
  localparam rel_set_t R_O  = 13'h0020;
  localparam rel_set_t R_OI = 13'h0040;
  localparam rel_set_t R_M  = 13'h0080;
  localparam rel_set_t R_MI = 13'h0100;
  localparam rel_set_t R_S  = 13'h0200;
  localparam rel_set_t R_SI = 13'h0400;
  localparam rel_set_t R_F  = 13'h0800;
  localparam rel_set_t R_FI = 13'h1000;

  localparam rel_set_t G_BEFD = R_B | R_O | R_M | R_D | R_S;
  localparam rel_set_t G_AFTD = R_BI | R_OI | R_MI | R_D | R_F;
  localparam rel_set_t G_BEFC = R_B | R_O | R_M | R_DI | R_FI;
  localparam rel_set_t G_AFTC = R_BI | R_OI | R_MI | R_DI | R_SI;
  localparam rel_set_t G_CONC = R_O | R_OI | R_D | R_S | R_F | R_DI | R_SI | R_FI | R_EQ;
  localparam rel_set_t G_ODS  = R_O | R_D | R_S;
  localparam rel_set_t G_ODF  = R_OI | R_D | R_F;
  localparam rel_set_t G_ODI  = R_O | R_DI | R_FI;
  localparam rel_set_t G_OIDI = R_OI | R_DI | R_SI;
  localparam rel_set_t G_BOM  = R_B | R_O | R_M;
  localparam rel_set_t G_BIOM = R_BI | R_OI | R_MI;
  localparam rel_set_t G_FEQ  = R_F | R_FI | R_EQ;
  localparam rel_set_t G_SEQ  = R_S | R_SI | R_EQ;

  // Row is the relation from A to B, column the relation from B to C.
  localparam rel_set_t COMP_TABLE [REL_W][REL_W] = '{
    '{R_EQ, R_B, R_BI, R_D, R_DI, R_O, R_OI, R_M, R_MI, R_S, R_SI, R_F, R_FI},
    '{R_B, R_B, REL_ALL, G_BEFD, R_B, R_B, G_BEFD, R_B, G_BEFD, R_B, R_B, G_BEFD, R_B},
    '{R_BI, REL_ALL, R_BI, G_AFTD, R_BI, G_AFTD, R_BI, G_AFTD, R_BI, G_AFTD, R_BI,
      R_BI, R_BI},
    '{R_D, R_B, R_BI, R_D, REL_ALL, G_BEFD, G_AFTD, R_B, R_BI, R_D, G_AFTD, R_D, G_BEFD},
    '{R_DI, G_BEFC, G_AFTC, G_CONC, R_DI, G_ODI, G_OIDI, G_ODI, G_OIDI, G_ODI, R_DI,
      G_OIDI, R_DI},
    '{R_O, R_B, G_AFTC, G_ODS, G_BEFC, G_BOM, G_CONC, R_B, G_OIDI, R_O, G_ODI, G_ODS,
      G_BOM},
    '{R_OI, G_BEFC, R_BI, G_ODF, G_AFTC, G_CONC, G_BIOM, G_ODI, R_BI, G_ODF, G_BIOM,
      R_OI, G_OIDI},
    '{R_M, R_B, G_AFTC, G_ODS, R_B, R_B, G_ODS, R_B, G_FEQ, R_M, R_M, G_ODS, R_B},
    '{R_MI, G_BEFC, R_BI, G_ODF, R_BI, G_ODF, R_BI, G_SEQ, R_BI, G_ODF, R_BI, R_MI, R_MI},
    '{R_S, R_B, R_BI, R_D, G_BEFC, G_BOM, G_ODF, R_B, R_MI, R_S, G_SEQ, R_D, G_BOM},
    '{R_SI, G_BEFC, R_BI, G_ODF, R_DI, G_ODI, R_OI, G_ODI, R_MI, G_SEQ, R_SI, R_OI, R_DI},
    '{R_F, R_B, R_BI, R_D, G_AFTC, G_ODS, G_BIOM, R_M, R_BI, R_D, G_BIOM, R_F, G_FEQ},
    '{R_FI, R_B, G_AFTC, G_ODS, R_DI, R_O, G_OIDI, R_M, G_OIDI, R_O, R_DI, G_FEQ, R_FI}
  };

  // Bit index of the converse of each relation.
  localparam logic [3:0] CONVERSE_OF [REL_W] = '{
    4'd0, 4'd2, 4'd1, 4'd4, 4'd3, 4'd6, 4'd5, 4'd8, 4'd7, 4'd10, 4'd9, 4'd12, 4'd11
  };

endpackage

/* rtl/interval_relation_set_compose.sv */
// Each accepted input word passes three register stages before its result word
// is offered on out_valid.
// Throughput: one word per cycle; the three stages advance together and hold
// while a finished result waits under out_stall.
// Reset: synchronous, active low; clears the stage valid bits only.
// ----------------------------------------------------------------------------
// interval_relation_set_compose: interval relation set composition
// Composes two relation sets through the composition table, or returns the
// converse of the first set, in a three stage pipeline.
// ----------------------------------------------------------------------------
module interval_relation_set_compose
  import irsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_action,
  input  rel_set_t in_first_set,
  input  rel_set_t in_second_set,
  output logic     out_valid,
  input  logic     out_stall,
  output rel_set_t out_result_set
);

  logic advance;

  // Stage 1: registered input word.
  logic     v1_r;
  logic     act1_r;
  rel_set_t s1_r;
  rel_set_t s2_r;

  // Stage 2: one masked table row union per relation of the first set.
  logic                       v2_r;
  logic                       act2_r;
  rel_set_t                   inv2_r;
  logic [REL_W-1:0][REL_W-1:0] rows2_r;
  logic [REL_W-1:0][REL_W-1:0] rows2_nxt;
  rel_set_t                   inv2_nxt;

  // Stage 3: output register.
  logic     v3_r;
  rel_set_t res3_r;
  rel_set_t res3_nxt;

  // The whole pipeline moves unless a finished word is held at the output.
  assign advance  = !(v3_r && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      act1_r  <= in_action;
      s1_r    <= in_first_set;
      s2_r    <= in_second_set;
      act2_r  <= act1_r;
      inv2_r  <= inv2_nxt;
      rows2_r <= rows2_nxt;
      res3_r  <= res3_nxt;
    end
  end

  always_comb begin
    rows2_nxt = '0;
    inv2_nxt  = '0;
    for (int i = 0; i < REL_W; i++) begin
      for (int j = 0; j < REL_W; j++) begin
        if (s1_r[i] && s2_r[j]) begin
          rows2_nxt[i] = rows2_nxt[i] | COMP_TABLE[i][j];
        end
      end
      inv2_nxt[CONVERSE_OF[i]] = s1_r[i];
    end
  end

  always_comb begin
    res3_nxt = '0;
    for (int i = 0; i < REL_W; i++) begin
      res3_nxt = res3_nxt | rows2_r[i];
    end
    if (act2_r) begin
      res3_nxt = inv2_r;
    end
  end

  assign out_valid      = v3_r;
  assign out_result_set = res3_r;

`ifndef NO_ASSERTIONS
  a_stall_only_on_held_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a held output word");

  a_invert_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v1_r && act1_r) |=> ($countones(inv2_r) == $countones($past(s1_r))))
    else $error("converse set lost or gained relations");

  a_empty_operand_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v1_r && !act1_r && ((s1_r == '0) || (s2_r == '0))) |=> (rows2_r == '0))
    else $error("composition with an empty set produced relations");

  a_stage2_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v2_r) |=> out_valid)
    else $error("word in flight did not reach the output register");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: interval relation set composition
// Sends compose and converse words through the block with random gaps on the
// input and random stalls on the output. Every result word is checked against
// a composition table and converse rule kept here.
// ----------------------------------------------------------------------------
module testbench
  import irsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_WORDS  = 1830;
  localparam int QUIET_WORDS   = 150;
  localparam int DRAIN_CYCLES  = 10;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_AT       = 300;
  localparam int REPORT_MAX    = 10;

  typedef enum logic {ACT_COMPOSE = 1'b0, ACT_INVERT = 1'b1} action_t;

  typedef struct packed {
    action_t  action;
    rel_set_t first_set;
    rel_set_t second_set;
  } relation_word_t;

  // Unions of basic relations that recur in the composition table.
  localparam rel_set_t BEF_IN   = R_B | R_O | R_M | R_D | R_S;
  localparam rel_set_t AFT_IN   = R_BI | R_OI | R_MI | R_D | R_F;
  localparam rel_set_t BEF_HOLD = R_B | R_O | R_M | R_DI | R_FI;
  localparam rel_set_t AFT_HOLD = R_BI | R_OI | R_MI | R_DI | R_SI;
  localparam rel_set_t SHARED   = R_O | R_OI | R_D | R_S | R_F | R_DI | R_SI | R_FI | R_EQ;
  localparam rel_set_t ODS      = R_O | R_D | R_S;
  localparam rel_set_t ODF      = R_OI | R_D | R_F;
  localparam rel_set_t ODIFI    = R_O | R_DI | R_FI;
  localparam rel_set_t OIDISI   = R_OI | R_DI | R_SI;
  localparam rel_set_t BOM      = R_B | R_O | R_M;
  localparam rel_set_t BIOIMI   = R_BI | R_OI | R_MI;
  localparam rel_set_t FFIEQ    = R_F | R_FI | R_EQ;
  localparam rel_set_t SSIEQ    = R_S | R_SI | R_EQ;

  // Row: relation from A to B. Column: relation from B to C.
  rel_set_t allen_table [REL_W][REL_W] = '{
    '{R_EQ, R_B, R_BI, R_D, R_DI, R_O, R_OI, R_M, R_MI, R_S, R_SI, R_F, R_FI},
    '{R_B, R_B, REL_ALL, BEF_IN, R_B, R_B, BEF_IN, R_B, BEF_IN, R_B, R_B, BEF_IN, R_B},
    '{R_BI, REL_ALL, R_BI, AFT_IN, R_BI, AFT_IN, R_BI, AFT_IN, R_BI, AFT_IN, R_BI,
      R_BI, R_BI},
    '{R_D, R_B, R_BI, R_D, REL_ALL, BEF_IN, AFT_IN, R_B, R_BI, R_D, AFT_IN, R_D, BEF_IN},
    '{R_DI, BEF_HOLD, AFT_HOLD, SHARED, R_DI, ODIFI, OIDISI, ODIFI, OIDISI, ODIFI, R_DI,
      OIDISI, R_DI},
    '{R_O, R_B, AFT_HOLD, ODS, BEF_HOLD, BOM, SHARED, R_B, OIDISI, R_O, ODIFI, ODS, BOM},
    '{R_OI, BEF_HOLD, R_BI, ODF, AFT_HOLD, SHARED, BIOIMI, ODIFI, R_BI, ODF, BIOIMI,
      R_OI, OIDISI},
    '{R_M, R_B, AFT_HOLD, ODS, R_B, R_B, ODS, R_B, FFIEQ, R_M, R_M, ODS, R_B},
    '{R_MI, BEF_HOLD, R_BI, ODF, R_BI, ODF, R_BI, SSIEQ, R_BI, ODF, R_BI, R_MI, R_MI},
    '{R_S, R_B, R_BI, R_D, BEF_HOLD, BOM, ODF, R_B, R_MI, R_S, SSIEQ, R_D, BOM},
    '{R_SI, BEF_HOLD, R_BI, ODF, R_DI, ODIFI, R_OI, ODIFI, R_MI, SSIEQ, R_SI, R_OI, R_DI},
    '{R_F, R_B, R_BI, R_D, AFT_HOLD, ODS, BIOIMI, R_M, R_BI, R_D, BIOIMI, R_F, FFIEQ},
    '{R_FI, R_B, AFT_HOLD, ODS, R_DI, R_O, OIDISI, R_M, OIDISI, R_O, R_DI, FFIEQ, R_FI}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     in_action = 1'b0;
  rel_set_t in_first_set = '0;
  rel_set_t in_second_set = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rel_set_t out_result_set;

  relation_word_t pending_words [$];
  rel_set_t       expected_sets [$];

  logic word_taken = 1'b0;
  int   in_gap_left = 0;
  int   out_stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   results_checked = 0;
  int   mismatch_count = 0;
  int   idle_cycles = 0;

  interval_relation_set_compose i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_first_set   (in_first_set),
    .in_second_set  (in_second_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_set (out_result_set)
  );

  always #10 clk = ~clk;

  function automatic rel_set_t compose_relations(rel_set_t a_to_b, rel_set_t b_to_c);
    rel_set_t acc = '0;
    for (int i = 0; i < REL_W; i++) begin
      for (int j = 0; j < REL_W; j++) begin
        if (a_to_b[i] && b_to_c[j]) begin
          acc = acc | allen_table[i][j];
        end
      end
    end
    return acc;
  endfunction

  // Equal is its own converse; every other relation sits in a pair with its
  // inverse at the next bit up.
  function automatic rel_set_t converse_relations(rel_set_t rels);
    rel_set_t acc = '0;
    acc[0] = rels[0];
    for (int k = 1; k < REL_W; k += 2) begin
      acc[k]   = rels[k+1];
      acc[k+1] = rels[k];
    end
    return acc;
  endfunction

  function automatic rel_set_t predict_result(relation_word_t word);
    if (word.action == ACT_INVERT) begin
      return converse_relations(word.first_set);
    end
    return compose_relations(word.first_set, word.second_set);
  endfunction

  // Mostly sparse sets, so that single table entries are seen on their own.
  function automatic rel_set_t random_relations();
    rel_set_t rels;
    case ($urandom_range(9, 0))
      0: rels = '0;
      1: rels = REL_ALL;
      2, 3, 4: rels = rel_set_t'(1) << $urandom_range(REL_W - 1, 0);
      5, 6: begin
        rels = (rel_set_t'(1) << $urandom_range(REL_W - 1, 0)) |
               (rel_set_t'(1) << $urandom_range(REL_W - 1, 0));
      end
      default: rels = rel_set_t'($urandom);
    endcase
    return rels;
  endfunction

  task automatic queue_word(action_t action, rel_set_t first_set, rel_set_t second_set);
    relation_word_t word;
    word.action     = action;
    word.first_set  = first_set;
    word.second_set = second_set;
    pending_words.push_back(word);
  endtask

  // Input side: record each accepted word and what it should produce.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_sets.push_back(predict_result({action_t'(in_action), in_first_set,
                                              in_second_set}));
      word_taken <= 1'b1;
    end else begin
      word_taken <= 1'b0;
    end
  end

  // Driver: a new word goes out only once the previous one has been taken.
  always @(negedge clk) begin
    relation_word_t word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (in_gap_left > 0) begin
        in_valid <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (pending_words.size() > QUIET_WORDS && $urandom_range(7, 0) == 0) begin
        in_valid <= 1'b0;
        in_gap_left <= $urandom_range(4, 1) - 1;
      end else if (pending_words.size() > 0) begin
        word = pending_words.pop_front();
        in_valid      <= 1'b1;
        in_action     <= word.action;
        in_first_set  <= word.first_set;
        in_second_set <= word.second_set;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, plus one long hold that backs up the pipe.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!hold_done && results_checked >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (out_stall_left > 0) begin
      out_stall <= 1'b1;
      out_stall_left <= out_stall_left - 1;
    end else if (pending_words.size() > QUIET_WORDS && $urandom_range(5, 0) == 0) begin
      out_stall <= 1'b1;
      out_stall_left <= $urandom_range(4, 1) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: each result word is matched against the oldest prediction.
  always @(posedge clk) begin
    rel_set_t wanted;
    if (rst_n && out_valid && !out_stall) begin
      results_checked <= results_checked + 1;
      if (expected_sets.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result word: result_set %h", out_result_set);
        end
      end else begin
        wanted = expected_sets.pop_front();
        if (out_result_set !== wanted) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result_set mismatch: expected %h, actual %h", wanted, out_result_set);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Empty and full operands, and alternating bit patterns for the converse.
    queue_word(ACT_COMPOSE, '0, '0);
    queue_word(ACT_COMPOSE, '0, REL_ALL);
    queue_word(ACT_COMPOSE, REL_ALL, '0);
    queue_word(ACT_COMPOSE, REL_ALL, REL_ALL);
    queue_word(ACT_INVERT, REL_ALL, '0);
    queue_word(ACT_INVERT, '0, REL_ALL);
    queue_word(ACT_INVERT, 13'h1555, 13'h0AAA);
    queue_word(ACT_INVERT, 13'h0AAA, 13'h1555);
    // Finished-by followed by after.
    queue_word(ACT_COMPOSE, R_FI, R_BI);
    for (int i = 0; i < REL_W; i++) begin
      queue_word(ACT_COMPOSE, rel_set_t'(1) << i, rel_set_t'(1) << ((i * 5) % REL_W));
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      queue_word($urandom_range(3, 0) == 0 ? ACT_INVERT : ACT_COMPOSE,
                 random_relations(), random_relations());
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_sets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_sets.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
